[rtl/core/rfom_pkg.sv]
// Package: payload types and constants of the radar frame obstacle monitor.
`timescale 1ns / 1ps

package rfom_pkg;

    // Obstacle class codes
    localparam logic [1:0] CLS_CLEAR = 2'd0;
    localparam logic [1:0] CLS_WARN  = 2'd1;
    localparam logic [1:0] CLS_BLOCK = 2'd2;

    // Item kinds
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [2:0] CFG_ENABLE  = 3'd0;
    localparam logic [2:0] CFG_TRIGGER = 3'd1;
    localparam logic [2:0] CFG_RELEASE = 3'd2;
    localparam logic [2:0] CFG_DEBOUNCE = 3'd3;
    localparam logic [2:0] CFG_TIMEOUT = 3'd4;

    // Register reset values
    localparam logic        RST_ENABLE   = 1'b1;
    localparam logic [15:0] RST_TRIGGER  = 16'd300;
    localparam logic [15:0] RST_RELEASE  = 16'd500;
    localparam logic [7:0]  RST_DEBOUNCE = 8'd3;
    localparam logic [31:0] RST_TIMEOUT  = 32'd500;

    // Sync header, first byte at index 0
    localparam int unsigned SYNC_LEN = 4;
    localparam logic [SYNC_LEN-1:0][7:0] SYNC_PAT = {8'hF1, 8'hF2, 8'hF3, 8'hF4};
    localparam int unsigned PAYLOAD_LEN = 3;

    localparam logic [7:0] DEB_MIN = 8'd1;
    localparam logic [7:0] DEB_MAX = 8'd20;
    localparam logic [7:0] RUN_MAX = 8'd255;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  data_byte;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  hazard_level;
        logic        frame_seen;
        logic        target_present;
        logic [15:0] range_mm;
        logic [31:0] good_frames;
        logic [31:0] checksum_errors;
        logic [31:0] last_frame_ms;
        logic        frame_done;
        logic        frame_bad;
    } t_out_item;

endpackage

[rtl/core/radar_frame_obstacle_monitor_core.sv]
// Top level: radar frame parser with debounced clear/warn/block classifier.
`timescale 1ns / 1ps

// Takes one item (a radar byte or a time tick) per cycle and returns exactly one
// result per item. An item waits in the input register; the parser, checksum
// and classifier then update all state in a single step and load the result
// register, which offers it. Sustained rate is one item per cycle while the
// result side does not stall; throughput is set by the state update (32-bit
// timeout subtract/compare and the debounce counters). The input side keeps
// taking items while a finished result waits, until both the input and result
// registers are full. Configuration is written through a plain write port, by
// the user only while idle (unenforced); writes to unknown indexes are dropped.
module radar_frame_obstacle_monitor_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rfom_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rfom_pkg::t_out_item o_out_data
);

    // Configuration
    logic        r_enable;
    logic [15:0] r_trigger;
    logic [15:0] r_release;
    logic [7:0]  r_debounce;
    logic [31:0] r_timeout;

    // Pipeline registers
    logic                r_in_valid;
    rfom_pkg::t_in_item  r_in;
    logic                r_out_valid;
    rfom_pkg::t_out_item r_out;

    // Monitor state
    logic [2:0]  r_hdr_pos, n_hdr_pos;
    logic [1:0]  r_pay_pos, n_pay_pos;
    logic [rfom_pkg::PAYLOAD_LEN-1:0][7:0] r_pay;
    logic        n_pay_we;
    logic [7:0]  r_near_run, n_near_run;
    logic [7:0]  r_far_run, n_far_run;
    logic [1:0]  r_cls, n_cls;
    logic        r_seen, n_seen;
    logic        r_target, n_target;
    logic [15:0] r_dist, n_dist;
    logic [31:0] r_good, n_good;
    logic [31:0] r_err, n_err;
    logic [31:0] r_stamp, n_stamp;
    logic        n_done, n_bad;

    logic s1_adv;

    assign s1_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || s1_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= rfom_pkg::RST_ENABLE;
            r_trigger  <= rfom_pkg::RST_TRIGGER;
            r_release  <= rfom_pkg::RST_RELEASE;
            r_debounce <= rfom_pkg::RST_DEBOUNCE;
            r_timeout  <= rfom_pkg::RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rfom_pkg::CFG_ENABLE:   r_enable   <= i_cfg_wdata[0];
                rfom_pkg::CFG_TRIGGER:  r_trigger  <= i_cfg_wdata[15:0];
                rfom_pkg::CFG_RELEASE:  r_release  <= i_cfg_wdata[15:0];
                rfom_pkg::CFG_DEBOUNCE: r_debounce <= i_cfg_wdata[7:0];
                rfom_pkg::CFG_TIMEOUT:  r_timeout  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Parser, checksum and classifier
    always_comb begin
        logic [7:0]  b;
        logic [7:0]  deb;
        logic [7:0]  xsum;
        logic [15:0] fdist;
        logic        ftgt;
        logic [7:0]  run_inc;
        logic [31:0] age;

        b     = r_in.data_byte;
        deb   = r_debounce;
        xsum  = r_pay[0] ^ r_pay[1] ^ r_pay[2];
        fdist = {r_pay[1], r_pay[0]};
        ftgt  = |r_pay[2];
        age   = r_in.now_ms - r_stamp;
        run_inc = 8'd0;

        if (deb < rfom_pkg::DEB_MIN) deb = rfom_pkg::DEB_MIN;
        if (deb > rfom_pkg::DEB_MAX) deb = rfom_pkg::DEB_MAX;

        n_hdr_pos  = r_hdr_pos;
        n_pay_pos  = r_pay_pos;
        n_pay_we   = 1'b0;
        n_near_run = r_near_run;
        n_far_run  = r_far_run;
        n_cls      = r_cls;
        n_seen     = r_seen;
        n_target   = r_target;
        n_dist     = r_dist;
        n_good     = r_good;
        n_err      = r_err;
        n_stamp    = r_stamp;
        n_done     = 1'b0;
        n_bad      = 1'b0;

        if (r_in.req_type == rfom_pkg::REQ_BYTE) begin
            if (r_enable) begin
                if (r_hdr_pos < 3'(rfom_pkg::SYNC_LEN)) begin
                    if (b == rfom_pkg::SYNC_PAT[r_hdr_pos[1:0]]) begin
                        n_hdr_pos = r_hdr_pos + 3'd1;
                    end else begin
                        n_hdr_pos = (b == rfom_pkg::SYNC_PAT[0]) ? 3'd1 : 3'd0;
                        n_pay_pos = 2'd0;
                    end
                end else if (r_pay_pos < 2'(rfom_pkg::PAYLOAD_LEN)) begin
                    n_pay_we  = 1'b1;
                    n_pay_pos = r_pay_pos + 2'd1;
                end else begin
                    n_hdr_pos = 3'd0;
                    n_pay_pos = 2'd0;
                    if (xsum != b) begin
                        n_err = r_err + 32'd1;
                        n_bad = 1'b1;
                    end else begin
                        n_done   = 1'b1;
                        n_seen   = 1'b1;
                        n_target = ftgt;
                        n_dist   = fdist;
                        n_good   = r_good + 32'd1;
                        n_stamp  = r_in.now_ms;
                        if (ftgt && fdist <= r_trigger) begin
                            // near frame: count toward block
                            run_inc    = (r_near_run < rfom_pkg::RUN_MAX) ?
                                         r_near_run + 8'd1 : r_near_run;
                            n_near_run = run_inc;
                            n_far_run  = 8'd0;
                            if (run_inc >= deb) n_cls = rfom_pkg::CLS_BLOCK;
                        end else begin
                            n_near_run = 8'd0;
                            if (r_cls == rfom_pkg::CLS_BLOCK) begin
                                if (!ftgt || fdist >= r_release) begin
                                    run_inc = (r_far_run < rfom_pkg::RUN_MAX) ?
                                              r_far_run + 8'd1 : r_far_run;
                                    n_far_run = run_inc;
                                    if (run_inc >= deb) begin
                                        n_cls     = rfom_pkg::CLS_CLEAR;
                                        n_far_run = 8'd0;
                                    end
                                end else begin
                                    n_far_run = 8'd0;
                                end
                            end else begin
                                n_cls = (ftgt && fdist <= r_release) ?
                                        rfom_pkg::CLS_WARN : rfom_pkg::CLS_CLEAR;
                                n_far_run = 8'd0;
                            end
                        end
                    end
                end
            end
        end else begin
            // tick: drop obstacle state when disabled, or when warn/block is stale
            if (!r_enable ||
                (r_cls != rfom_pkg::CLS_CLEAR && age > r_timeout)) begin
                n_near_run = 8'd0;
                n_far_run  = 8'd0;
                n_cls      = rfom_pkg::CLS_CLEAR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_hdr_pos   <= 3'd0;
            r_pay_pos   <= 2'd0;
            r_near_run  <= 8'd0;
            r_far_run   <= 8'd0;
            r_cls       <= rfom_pkg::CLS_CLEAR;
            r_seen      <= 1'b0;
            r_target    <= 1'b0;
            r_dist      <= 16'd0;
            r_good      <= 32'd0;
            r_err       <= 32'd0;
            r_stamp     <= 32'd0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_hdr_pos  <= n_hdr_pos;
                r_pay_pos  <= n_pay_pos;
                r_near_run <= n_near_run;
                r_far_run  <= n_far_run;
                r_cls      <= n_cls;
                r_seen     <= n_seen;
                r_target   <= n_target;
                r_dist     <= n_dist;
                r_good     <= n_good;
                r_err      <= n_err;
                r_stamp    <= n_stamp;
            end
        end
    end

    // Payload registers: input item, payload bytes, result
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (s1_adv && n_pay_we) begin
            r_pay[r_pay_pos] <= r_in.data_byte;
        end
        if (s1_adv) begin
            r_out.hazard_level    <= n_cls;
            r_out.frame_seen      <= n_seen;
            r_out.target_present  <= n_target;
            r_out.range_mm        <= n_dist;
            r_out.good_frames     <= n_good;
            r_out.checksum_errors <= n_err;
            r_out.last_frame_ms   <= n_stamp;
            r_out.frame_done      <= n_done;
            r_out.frame_bad       <= n_bad;
        end
    end

endmodule

[rtl/core/rfom_checker.sv]
// Checker: port-level properties of the radar frame obstacle monitor.
`timescale 1ns / 1ps

module rfom_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input rfom_pkg::t_out_item o_out_data
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // With no result pending the input side never stalls
    a_in_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    a_done_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.frame_done && o_out_data.frame_bad))
        else $error("frame both good and bad");

    a_state_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.hazard_level <= rfom_pkg::CLS_BLOCK)
        else $error("illegal obstacle state");

    // Warn, block and good frames all require a frame seen
    a_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.frame_done ||
            o_out_data.hazard_level != rfom_pkg::CLS_CLEAR)
        |-> o_out_data.frame_seen)
        else $error("obstacle or frame without a good frame seen");

endmodule

bind radar_frame_obstacle_monitor_core rfom_checker u_rfom_checker (.*);

[tb/rfom_report_checker.sv]
// Checker: predicts each obstacle report from the input transfers and compares the block's output.
`timescale 1ns / 1ps

module rfom_report_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_wdata,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  rfom_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  rfom_pkg::t_out_item i_out_data,
    output int                  o_mismatches,
    output int                  o_pending
);

    // Configuration as the block sees it
    logic        cfg_enable;
    logic [15:0] cfg_trigger;
    logic [15:0] cfg_release;
    logic [7:0]  cfg_debounce;
    logic [31:0] cfg_timeout;

    // Parser and classifier state
    int unsigned hdr_pos;
    int unsigned pay_pos;
    logic [7:0]  pay_bytes [rfom_pkg::PAYLOAD_LEN];
    logic [7:0]  near_run;
    logic [7:0]  far_run;
    logic [1:0]  class_now;
    logic        seen_good;
    logic        last_tgt;
    logic [15:0] last_dist;
    logic [31:0] good_cnt;
    logic [31:0] bad_cnt;
    logic [31:0] last_ms;

    rfom_pkg::t_out_item expected_reports [$];
    int                  mismatch_total = 0;

    assign o_mismatches = mismatch_total;

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_total++;
        end
    endtask

    task automatic clear_obstacle();
        near_run  = '0;
        far_run   = '0;
        class_now = rfom_pkg::CLS_CLEAR;
    endtask

    task automatic predict_report(input rfom_pkg::t_in_item it,
                                  output rfom_pkg::t_out_item rep);
        logic [7:0]  deb;
        logic [7:0]  sum;
        logic [15:0] frange;
        logic        tgt;
        logic        done;
        logic        bad;
        logic [31:0] age;
        done = 1'b0;
        bad  = 1'b0;
        if (it.req_type == rfom_pkg::REQ_BYTE) begin
            if (cfg_enable) begin
                if (hdr_pos < rfom_pkg::SYNC_LEN) begin
                    if (it.data_byte == rfom_pkg::SYNC_PAT[hdr_pos]) begin
                        hdr_pos++;
                    end else begin
                        // restart the match, keeping a fresh first sync byte
                        hdr_pos = (it.data_byte == rfom_pkg::SYNC_PAT[0]) ? 1 : 0;
                        pay_pos = 0;
                    end
                end else if (pay_pos < rfom_pkg::PAYLOAD_LEN) begin
                    pay_bytes[pay_pos] = it.data_byte;
                    pay_pos++;
                end else begin
                    sum = pay_bytes[0] ^ pay_bytes[1] ^ pay_bytes[2];
                    if (sum != it.data_byte) begin
                        bad_cnt = bad_cnt + 32'd1;
                        bad     = 1'b1;
                    end else begin
                        frange    = {pay_bytes[1], pay_bytes[0]};
                        tgt       = (pay_bytes[2] != 8'd0);
                        seen_good = 1'b1;
                        last_tgt  = tgt;
                        last_dist = frange;
                        good_cnt  = good_cnt + 32'd1;
                        last_ms   = it.now_ms;
                        done      = 1'b1;
                        deb = cfg_debounce;
                        if (deb < rfom_pkg::DEB_MIN) deb = rfom_pkg::DEB_MIN;
                        else if (deb > rfom_pkg::DEB_MAX) deb = rfom_pkg::DEB_MAX;
                        if (tgt && frange <= cfg_trigger) begin
                            if (near_run < rfom_pkg::RUN_MAX) near_run++;
                            far_run = '0;
                            if (near_run >= deb) class_now = rfom_pkg::CLS_BLOCK;
                        end else begin
                            near_run = '0;
                            if (class_now == rfom_pkg::CLS_BLOCK) begin
                                if (!tgt || frange >= cfg_release) begin
                                    if (far_run < rfom_pkg::RUN_MAX) far_run++;
                                    if (far_run >= deb) begin
                                        class_now = rfom_pkg::CLS_CLEAR;
                                        far_run   = '0;
                                    end
                                end else begin
                                    far_run = '0;
                                end
                            end else begin
                                class_now = (tgt && frange <= cfg_release) ?
                                            rfom_pkg::CLS_WARN : rfom_pkg::CLS_CLEAR;
                                far_run   = '0;
                            end
                        end
                    end
                    hdr_pos = 0;
                    pay_pos = 0;
                end
            end
        end else begin
            age = it.now_ms - last_ms;
            if (!cfg_enable) clear_obstacle();
            else if (class_now != rfom_pkg::CLS_CLEAR && age > cfg_timeout) clear_obstacle();
        end
        rep.hazard_level    = class_now;
        rep.frame_seen      = seen_good;
        rep.target_present  = last_tgt;
        rep.range_mm        = last_dist;
        rep.good_frames     = good_cnt;
        rep.checksum_errors = bad_cnt;
        rep.last_frame_ms   = last_ms;
        rep.frame_done      = done;
        rep.frame_bad       = bad;
    endtask

    always @(posedge i_clk) begin
        rfom_pkg::t_out_item want;
        rfom_pkg::t_out_item got;
        if (!i_rst_n) begin
            cfg_enable   = rfom_pkg::RST_ENABLE;
            cfg_trigger  = rfom_pkg::RST_TRIGGER;
            cfg_release  = rfom_pkg::RST_RELEASE;
            cfg_debounce = rfom_pkg::RST_DEBOUNCE;
            cfg_timeout  = rfom_pkg::RST_TIMEOUT;
            hdr_pos   = 0;
            pay_pos   = 0;
            for (int i = 0; i < rfom_pkg::PAYLOAD_LEN; i++) pay_bytes[i] = '0;
            clear_obstacle();
            seen_good = 1'b0;
            last_tgt  = 1'b0;
            last_dist = '0;
            good_cnt  = '0;
            bad_cnt   = '0;
            last_ms   = '0;
            expected_reports.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = i_out_data;
                if (expected_reports.size() == 0) begin
                    $error("report transfer with no expectation waiting: 0x%0h", got);
                    mismatch_total++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("hazard_level", 32'(want.hazard_level),
                                32'(got.hazard_level));
                    check_field("frame_seen", 32'(want.frame_seen), 32'(got.frame_seen));
                    check_field("target_present", 32'(want.target_present),
                                32'(got.target_present));
                    check_field("range_mm", 32'(want.range_mm), 32'(got.range_mm));
                    check_field("good_frames", want.good_frames, got.good_frames);
                    check_field("checksum_errors", want.checksum_errors,
                                got.checksum_errors);
                    check_field("last_frame_ms", want.last_frame_ms, got.last_frame_ms);
                    check_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
                    check_field("frame_bad", 32'(want.frame_bad), 32'(got.frame_bad));
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    rfom_pkg::CFG_ENABLE:   cfg_enable   = i_cfg_wdata[0];
                    rfom_pkg::CFG_TRIGGER:  cfg_trigger  = i_cfg_wdata[15:0];
                    rfom_pkg::CFG_RELEASE:  cfg_release  = i_cfg_wdata[15:0];
                    rfom_pkg::CFG_DEBOUNCE: cfg_debounce = i_cfg_wdata[7:0];
                    rfom_pkg::CFG_TIMEOUT:  cfg_timeout  = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_report(i_in_data, want);
                expected_reports.push_back(want);
            end
        end
        o_pending <= expected_reports.size();
    end

endmodule

[tb/radar_frame_obstacle_monitor_core_tb.sv]
// Testbench top: drives radar bytes, ticks and register writes into the monitor core.
`timescale 1ns / 1ps

module radar_frame_obstacle_monitor_core_tb;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [2:0]          cfg_idx   = rfom_pkg::CFG_ENABLE;
    logic [31:0]         cfg_wdata = '0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    rfom_pkg::t_in_item  in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    rfom_pkg::t_out_item out_data;
    int                  mismatch_count;
    int                  reports_outstanding;

    // Traffic shaping, percent per cycle
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic hold_req  = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    // Shadow of the settings and of the time base, used to aim the stimulus
    logic        tb_enable  = rfom_pkg::RST_ENABLE;
    logic [15:0] tb_trig    = rfom_pkg::RST_TRIGGER;
    logic [15:0] tb_rel     = rfom_pkg::RST_RELEASE;
    logic [31:0] tb_timeout = rfom_pkg::RST_TIMEOUT;
    logic [31:0] t_ms       = '0;
    logic [31:0] last_good_ms = '0;
    int          items_sent = 0;

    always #5 clk = ~clk;

    radar_frame_obstacle_monitor_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    rfom_report_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_mismatches (mismatch_count),
        .o_pending    (reports_outstanding)
    );

    // Result side: random stalls, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_item(input logic kind, input logic [7:0] b, input logic [31:0] now);
        rfom_pkg::t_in_item it;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        it.req_type  = kind;
        it.data_byte = b;
        it.now_ms    = now;
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_ms = t_ms + $urandom_range(0, 3);
        send_item(rfom_pkg::REQ_BYTE, b, t_ms);
    endtask

    task automatic send_frame(input logic [15:0] rng_mm, input logic [7:0] flag,
                              input bit corrupt);
        logic [7:0] sum;
        sum = rng_mm[7:0] ^ rng_mm[15:8] ^ flag;
        if (corrupt) sum = sum ^ (8'd1 << $urandom_range(7));
        for (int i = 0; i < rfom_pkg::SYNC_LEN; i++) send_byte(rfom_pkg::SYNC_PAT[i]);
        send_byte(rng_mm[7:0]);
        send_byte(rng_mm[15:8]);
        send_byte(flag);
        send_byte(sum);
        if (!corrupt && tb_enable) last_good_ms = t_ms;
    endtask

    // Aim ticks around the staleness bound of the last good frame
    task automatic send_tick();
        int r;
        r = $urandom_range(99);
        if (r < 50) t_ms = t_ms + $urandom_range(0, 30);
        else if (r < 65) t_ms = last_good_ms + tb_timeout;
        else if (r < 80) t_ms = last_good_ms + tb_timeout + 32'd1;
        else if (r < 90) t_ms = $urandom;
        else t_ms = t_ms + $urandom_range(0, 1000);
        send_item(rfom_pkg::REQ_TICK, 8'($urandom), t_ms);
    endtask

    function automatic logic [15:0] zone_distance(input int zone);
        case (zone)
            0: return 16'($urandom_range(0, tb_trig));
            1: return 16'($urandom_range(tb_trig, tb_rel));
            2: return 16'($urandom_range(tb_rel, 16'hFFFF));
            default: begin
                case ($urandom_range(4))
                    0: return tb_trig;
                    1: return tb_trig + 16'd1;
                    2: return tb_rel;
                    3: return tb_rel - 16'd1;
                    default: return 16'($urandom);
                endcase
            end
        endcase
    endfunction

    task automatic apply_settings(input logic en, input logic [15:0] trig,
                                  input logic [15:0] rel, input logic [7:0] deb,
                                  input logic [31:0] tmo);
        cfg_we <= 1'b1;
        cfg_idx <= rfom_pkg::CFG_ENABLE;   cfg_wdata <= {31'd0, en};   @(posedge clk);
        cfg_idx <= rfom_pkg::CFG_TRIGGER;  cfg_wdata <= {16'd0, trig}; @(posedge clk);
        cfg_idx <= rfom_pkg::CFG_RELEASE;  cfg_wdata <= {16'd0, rel};  @(posedge clk);
        cfg_idx <= rfom_pkg::CFG_DEBOUNCE; cfg_wdata <= {24'd0, deb};  @(posedge clk);
        cfg_idx <= rfom_pkg::CFG_TIMEOUT;  cfg_wdata <= tmo;           @(posedge clk);
        cfg_we <= 1'b0;
        tb_enable  = en;
        tb_trig    = trig;
        tb_rel     = rel;
        tb_timeout = tmo;
    endtask

    // Drop valid and wait until every report has come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (reports_outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(input int n_items, input int sidle, input int rstall,
                             input bit squeeze);
        int stop_at;
        int r;
        int zone;
        int len;
        bit held;
        logic [7:0] flag;
        send_idle_pct  = sidle;
        recv_stall_pct = rstall;
        stop_at = items_sent + n_items;
        held = 1'b0;
        while (items_sent < stop_at) begin
            if (squeeze && !held && items_sent > stop_at - n_items / 2) begin
                hold_req <= ~hold_req;
                held = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 70) begin
                // run of frames in one distance zone to walk the debounce
                zone = $urandom_range(3);
                len  = $urandom_range(1, 22);
                for (int k = 0; k < len; k++) begin
                    flag = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
                    send_frame(zone_distance(zone), flag, $urandom_range(99) < 8);
                    if ($urandom_range(99) < 15) send_tick();
                end
            end else if (r < 82) begin
                send_tick();
            end else if (r < 92) begin
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++)
                    send_byte(($urandom_range(3) == 0) ? rfom_pkg::SYNC_PAT[0] : 8'($urandom));
            end else if ($urandom_range(1) == 0) begin
                // header cut short
                len = $urandom_range(1, 3);
                for (int k = 0; k < len; k++) send_byte(rfom_pkg::SYNC_PAT[k]);
                send_byte(8'($urandom));
            end else begin
                // header with a truncated payload; the next bytes complete it
                for (int k = 0; k < rfom_pkg::SYNC_LEN; k++) send_byte(rfom_pkg::SYNC_PAT[k]);
                len = $urandom_range(0, 3);
                for (int k = 0; k < len; k++) send_byte(8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: tick on empty state, extreme good frame, header restart, bad checksum
        send_item(rfom_pkg::REQ_TICK, 8'h00, 32'h0000_0000);
        send_frame(16'hFFFF, 8'hFF, 1'b0);
        send_byte(rfom_pkg::SYNC_PAT[0]);
        send_byte(rfom_pkg::SYNC_PAT[0]);
        send_byte(rfom_pkg::SYNC_PAT[1]);
        send_byte(8'h00);
        send_frame(16'h0000, 8'h00, 1'b1);
        send_item(rfom_pkg::REQ_TICK, 8'hFF, 32'hFFFF_FFFF);
        settle();

        apply_settings(1'b1, 16'd300, 16'd500, 8'd3, 32'd500);
        run_phase(210, 0, 0, 1'b1);
        settle();

        apply_settings(1'b1, 16'd1000, 16'd2000, 8'd0, 32'd0);
        run_phase(210, 53, 0, 1'b0);
        settle();

        // Let the time base wrap during this phase
        t_ms = 32'hFFFF_F000;
        apply_settings(1'b1, 16'hFFFF, 16'hFFFF, 8'd20, 32'hFFFF_FFFF);
        run_phase(210, 0, 53, 1'b1);
        settle();

        // Crossed thresholds; leave the parser inside a header
        apply_settings(1'b1, 16'd2000, 16'd1000, 8'd255, 32'd100);
        run_phase(210, 11, 11, 1'b0);
        send_byte(rfom_pkg::SYNC_PAT[0]);
        send_byte(rfom_pkg::SYNC_PAT[1]);
        settle();

        apply_settings(1'b0, 16'd0, 16'd0, 8'd1, 32'd50);
        run_phase(80, 0, 0, 1'b0);
        settle();

        // Resume the held header: a near frame at zero distance
        apply_settings(1'b1, 16'd0, 16'd0, 8'd1, 32'd50);
        send_byte(rfom_pkg::SYNC_PAT[2]);
        send_byte(rfom_pkg::SYNC_PAT[3]);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h01);
        run_phase(210, 11, 11, 1'b1);
        settle();

        if (mismatch_count == 0) begin
            $display("radar_frame_obstacle_monitor_core_tb OK");
        end else begin
            $display("radar_frame_obstacle_monitor_core_tb NOT OK");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("radar_frame_obstacle_monitor_core_tb NOT OK");
        $finish;
    end

endmodule
